// ----- hdl/ps2mct_pkg.sv -----
// Shared types and constants for the PS/2 mouse cursor tracker.
// Used by the packet decoder, the pixel generator and the top level.
package ps2mct_pkg;

    localparam int POS_W = 11;

    localparam int STATUS_READY_BIT = 0;
    localparam int STATUS_AUX_BIT   = 5;

    localparam int CFG_INDEX_W = 8;

    localparam logic [7:0] IDLE_COLOR_RESET    = 8'h0F;
    localparam logic [7:0] PRESSED_COLOR_RESET = 8'h0C;
    localparam logic [8:0] CURSOR_X_RESET      = 9'd160;
    localparam logic [7:0] CURSOR_Y_RESET      = 8'd100;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IDLE_COLOR    = 8'd0,
        REG_PRESSED_COLOR = 8'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [POS_W-1:0] x_pos;
        logic [POS_W-1:0] y_pos;
        logic [8:0]       cursor_col;
        logic [7:0]       cursor_row;
        logic [7:0]       color;
    } run_t;

endpackage

// ----- hdl/ps2_mouse_cursor_tracker_core.sv -----
// Top level of the PS/2 mouse cursor tracker: color registers and the two datapath parts.
// Depends on ps2mct_pkg, ps2mct_packet and ps2mct_pixel_gen.
//
// Each transfer on the input channel is one controller read; it counts as a mouse byte
// only when status bits 0 and 5 are both set. The first two bytes of a packet are taken
// one per cycle and only held. The third byte moves and clamps the cursor and starts a
// run of CURSOR_SIZE * CURSOR_SIZE pixel writes (25 by default), one per cycle while the
// output side takes them, row by row from the top left corner. The run counter is the
// limit: the third byte of the next packet is held off until the current run has left
// the generator. Bytes of the next packet other than the third are taken while a run is
// still being written.
module ps2_mouse_cursor_tracker_core
    import ps2mct_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 200,
    parameter int CURSOR_SIZE   = 5
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             controller_status,
    input  logic [7:0]             data_byte,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [15:0]            pixel_address,
    output logic [7:0]             pixel_color,
    output logic [8:0]             cursor_col,
    output logic [7:0]             cursor_row,
    output logic                   last_pixel
);

    logic [7:0] idle_color_reg, idle_color_next;
    logic [7:0] pressed_color_reg, pressed_color_next;
    logic       run_load;
    logic       run_busy;
    run_t       run;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        idle_color_next    = idle_color_reg;
        pressed_color_next = pressed_color_reg;
        if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_IDLE_COLOR:    idle_color_next = cfg_data;
                REG_PRESSED_COLOR: pressed_color_next = cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_color_reg    <= IDLE_COLOR_RESET;
            pressed_color_reg <= PRESSED_COLOR_RESET;
        end
        else
        begin
            idle_color_reg    <= idle_color_next;
            pressed_color_reg <= pressed_color_next;
        end
    end

    ps2mct_packet #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .CURSOR_SIZE   (CURSOR_SIZE)
    ) u_packet (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .controller_status (controller_status),
        .data_byte         (data_byte),
        .idle_color        (idle_color_reg),
        .pressed_color     (pressed_color_reg),
        .run_busy          (run_busy),
        .run_load          (run_load),
        .run               (run)
    );

    ps2mct_pixel_gen #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .CURSOR_SIZE  (CURSOR_SIZE)
    ) u_pixel_gen (
        .clk           (clk),
        .rst_n         (rst_n),
        .run_load      (run_load),
        .run           (run),
        .run_busy      (run_busy),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_address (pixel_address),
        .pixel_color   (pixel_color),
        .cursor_col    (cursor_col),
        .cursor_row    (cursor_row),
        .last_pixel    (last_pixel)
    );

endmodule

// ----- hdl/ps2mct_packet.sv -----
// Gathers accepted mouse bytes into three-byte packets and updates the cursor.
// Depends on ps2mct_pkg; hands a finished packet to ps2mct_pixel_gen as a run_t.
module ps2mct_packet
    import ps2mct_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 200,
    parameter int CURSOR_SIZE   = 5
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] controller_status,
    input  logic [7:0] data_byte,
    input  logic [7:0] idle_color,
    input  logic [7:0] pressed_color,
    input  logic       run_busy,
    output logic       run_load,
    output run_t       run
);

    typedef enum logic [1:0] {
        PKT_BUTTON,
        PKT_X_MOTION,
        PKT_Y_MOTION
    } pkt_phase_t;

    localparam logic signed [POS_W+1:0] X_HI = (POS_W+2)'(SCREEN_WIDTH - CURSOR_SIZE);
    localparam logic signed [POS_W+1:0] Y_HI = (POS_W+2)'(SCREEN_HEIGHT - CURSOR_SIZE);

    pkt_phase_t              phase_reg, phase_next;
    logic [7:0]              held_button_reg, held_button_next;
    logic [7:0]              held_x_reg, held_x_next;
    logic [8:0]              cursor_x_reg, cursor_x_next;
    logic [7:0]              cursor_y_reg, cursor_y_next;
    logic                    take;
    logic signed [POS_W+1:0] nx_calc;
    logic signed [POS_W+1:0] ny_calc;
    logic [POS_W-1:0]        nx_clamp;
    logic [POS_W-1:0]        ny_clamp;

    assign in_ready = (phase_reg != PKT_Y_MOTION) || !run_busy;
    assign take     = in_valid && in_ready && controller_status[STATUS_READY_BIT]
                      && controller_status[STATUS_AUX_BIT];

    assign nx_calc = $signed({{(POS_W-7){1'b0}}, cursor_x_reg})
                     + $signed({{(POS_W-6){held_x_reg[7]}}, held_x_reg});
    assign ny_calc = $signed({{(POS_W-6){1'b0}}, cursor_y_reg})
                     - $signed({{(POS_W-6){data_byte[7]}}, data_byte});

    always_comb
    begin
        if (nx_calc[POS_W+1])
        begin
            nx_clamp = '0;
        end
        else if (nx_calc > X_HI)
        begin
            nx_clamp = X_HI[POS_W-1:0];
        end
        else
        begin
            nx_clamp = nx_calc[POS_W-1:0];
        end

        if (ny_calc[POS_W+1])
        begin
            ny_clamp = '0;
        end
        else if (ny_calc > Y_HI)
        begin
            ny_clamp = Y_HI[POS_W-1:0];
        end
        else
        begin
            ny_clamp = ny_calc[POS_W-1:0];
        end
    end

    always_comb
    begin
        phase_next       = phase_reg;
        held_button_next = held_button_reg;
        held_x_next      = held_x_reg;
        cursor_x_next    = cursor_x_reg;
        cursor_y_next    = cursor_y_reg;
        run_load         = 1'b0;
        if (take)
        begin
            case (phase_reg)
                PKT_BUTTON:
                begin
                    held_button_next = data_byte;
                    phase_next       = PKT_X_MOTION;
                end
                PKT_X_MOTION:
                begin
                    held_x_next = data_byte;
                    phase_next  = PKT_Y_MOTION;
                end
                PKT_Y_MOTION:
                begin
                    cursor_x_next = nx_clamp[8:0];
                    cursor_y_next = ny_clamp[7:0];
                    phase_next    = PKT_BUTTON;
                    run_load      = 1'b1;
                end
                default:
                begin
                    phase_next = PKT_BUTTON;
                end
            endcase
        end
    end

    assign run.x_pos      = nx_clamp;
    assign run.y_pos      = ny_clamp;
    assign run.cursor_col = nx_clamp[8:0];
    assign run.cursor_row = ny_clamp[7:0];
    assign run.color      = held_button_reg[0] ? pressed_color : idle_color;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PKT_BUTTON;
            held_button_reg <= '0;
            held_x_reg      <= '0;
            cursor_x_reg    <= CURSOR_X_RESET;
            cursor_y_reg    <= CURSOR_Y_RESET;
        end
        else
        begin
            phase_reg       <= phase_next;
            held_button_reg <= held_button_next;
            held_x_reg      <= held_x_next;
            cursor_x_reg    <= cursor_x_next;
            cursor_y_reg    <= cursor_y_next;
        end
    end

endmodule

// ----- hdl/ps2mct_pixel_gen.sv -----
// Walks the cursor square row by row and drives the registered pixel writes.
// Depends on ps2mct_pkg; takes a run_t from ps2mct_packet.
module ps2mct_pixel_gen
    import ps2mct_pkg::*;
#(
    parameter int SCREEN_WIDTH = 320,
    parameter int CURSOR_SIZE  = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        run_load,
    input  run_t        run,
    output logic        run_busy,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] pixel_address,
    output logic [7:0]  pixel_color,
    output logic [8:0]  cursor_col,
    output logic [7:0]  cursor_row,
    output logic        last_pixel
);

    localparam int CNT_W  = $clog2(CURSOR_SIZE + 1);
    localparam int ADDR_W = 2 * POS_W + 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CURSOR_SIZE - 1);

    logic              active_reg, active_next;
    run_t              run_reg, run_next;
    logic [CNT_W-1:0]  row_cnt_reg, row_cnt_next;
    logic [CNT_W-1:0]  col_cnt_reg, col_cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic [15:0]       addr_reg, addr_next;
    logic [7:0]        color_reg, color_next;
    logic [8:0]        col_reg, col_next;
    logic [7:0]        row_reg, row_next;
    logic              last_reg, last_next;
    logic              advance;
    logic              at_last;
    logic [POS_W:0]    row_pos;
    logic [POS_W:0]    col_pos;
    logic [ADDR_W-1:0] addr_full;

    assign advance  = active_reg && (!out_valid_reg || out_ready);
    assign at_last  = (row_cnt_reg == CNT_LAST) && (col_cnt_reg == CNT_LAST);
    assign row_pos  = {1'b0, run_reg.y_pos} + (POS_W+1)'(row_cnt_reg);
    assign col_pos  = {1'b0, run_reg.x_pos} + (POS_W+1)'(col_cnt_reg);
    assign addr_full = ADDR_W'(row_pos) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(col_pos);

    always_comb
    begin
        active_next    = active_reg;
        run_next       = run_reg;
        row_cnt_next   = row_cnt_reg;
        col_cnt_next   = col_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        addr_next      = addr_reg;
        color_next     = color_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        last_next      = last_reg;
        if (run_load)
        begin
            active_next  = 1'b1;
            run_next     = run;
            row_cnt_next = '0;
            col_cnt_next = '0;
        end
        else if (advance)
        begin
            out_valid_next = 1'b1;
            addr_next      = addr_full[15:0];
            color_next     = run_reg.color;
            col_next       = run_reg.cursor_col;
            row_next       = run_reg.cursor_row;
            last_next      = at_last;
            if (at_last)
            begin
                active_next = 1'b0;
            end
            if (col_cnt_reg == CNT_LAST)
            begin
                col_cnt_next = '0;
                row_cnt_next = row_cnt_reg + 1'b1;
            end
            else
            begin
                col_cnt_next = col_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            row_cnt_reg   <= '0;
            col_cnt_reg   <= '0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            row_cnt_reg   <= row_cnt_next;
            col_cnt_reg   <= col_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_reg   <= run_next;
        addr_reg  <= addr_next;
        color_reg <= color_next;
        col_reg   <= col_next;
        row_reg   <= row_next;
        last_reg  <= last_next;
    end

    assign run_busy      = active_reg;
    assign out_valid     = out_valid_reg;
    assign pixel_address = addr_reg;
    assign pixel_color   = color_reg;
    assign cursor_col    = col_reg;
    assign cursor_row    = row_reg;
    assign last_pixel    = last_reg;

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for ps2_mouse_cursor_tracker_core: a scoreboard class predicts the
// cursor square for every mouse packet and checks each pixel write in order of arrival.
// Depends on ps2mct_pkg and the RTL of ps2_mouse_cursor_tracker_core.
module tb_top;
    import ps2mct_pkg::*;

    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 200;
    localparam int CURSOR_SIZE   = 5;
    localparam int MAX_X         = SCREEN_WIDTH - CURSOR_SIZE;
    localparam int MAX_Y         = SCREEN_HEIGHT - CURSOR_SIZE;
    localparam int HOLD_CYCLES   = 200;

    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_LOW  = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_HIGH = 8'd255;
    localparam logic [7:0] STATUS_MOUSE =
        (8'h01 << STATUS_READY_BIT) | (8'h01 << STATUS_AUX_BIT);

    typedef struct packed {
        logic [15:0] address;
        logic [7:0]  color;
        logic [8:0]  col;
        logic [7:0]  row;
        logic        last;
    } pixel_write_t;

    class cursor_pixel_board;
        logic [7:0]   idle_color;
        logic [7:0]   pressed_color;
        logic [1:0]   byte_count;
        logic [7:0]   button_byte;
        logic [7:0]   x_motion;
        int           cursor_x;
        int           cursor_y;
        pixel_write_t pending_pixels[$];
        int           mismatches;
        int           pixels_checked;
        int           packets_done;
        int           clamp_hits;

        function new();
            idle_color     = IDLE_COLOR_RESET;
            pressed_color  = PRESSED_COLOR_RESET;
            byte_count     = 2'd0;
            button_byte    = 8'h00;
            x_motion       = 8'h00;
            cursor_x       = CURSOR_X_RESET;
            cursor_y       = CURSOR_Y_RESET;
            mismatches     = 0;
            pixels_checked = 0;
            packets_done   = 0;
            clamp_hits     = 0;
        endfunction

        function void report_mismatch(string what, int got_value, int want_value);
            $display("mismatch at %0t: %s, got %0d, expected %0d",
                     $realtime, what, got_value, want_value);
            mismatches++;
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] index, logic [7:0] value);
            case (index)
                REG_IDLE_COLOR:    idle_color = value;
                REG_PRESSED_COLOR: pressed_color = value;
                default: ;
            endcase
        endfunction

        function int clamp(int v, int hi);
            if (v < 0)
            begin
                clamp_hits++;
                return 0;
            end
            if (v > hi)
            begin
                clamp_hits++;
                return hi;
            end
            return v;
        endfunction

        function void take_mouse_read(logic [7:0] status, logic [7:0] value);
            int           nx;
            int           ny;
            logic [7:0]   color;
            pixel_write_t px;
            if (!(status[STATUS_READY_BIT] && status[STATUS_AUX_BIT]))
                return;
            if (byte_count == 2'd0)
            begin
                button_byte = value;
                byte_count = 2'd1;
                return;
            end
            if (byte_count == 2'd1)
            begin
                x_motion = value;
                byte_count = 2'd2;
                return;
            end
            byte_count = 2'd0;
            nx = clamp(cursor_x + int'($signed(x_motion)), MAX_X);
            ny = clamp(cursor_y - int'($signed(value)), MAX_Y);
            cursor_x = nx;
            cursor_y = ny;
            color = button_byte[0] ? pressed_color : idle_color;
            for (int r = 0; r < CURSOR_SIZE; r++)
            begin
                for (int c = 0; c < CURSOR_SIZE; c++)
                begin
                    px.address = 16'((ny + r) * SCREEN_WIDTH + nx + c);
                    px.color   = color;
                    px.col     = 9'(nx);
                    px.row     = 8'(ny);
                    px.last    = (r == CURSOR_SIZE - 1) && (c == CURSOR_SIZE - 1);
                    pending_pixels.push_back(px);
                end
            end
            packets_done++;
        endfunction

        function void match_pixel_write(pixel_write_t got);
            pixel_write_t want;
            if (pending_pixels.size() == 0)
            begin
                report_mismatch("pixel write with none expected, address", got.address, 0);
                return;
            end
            want = pending_pixels.pop_front();
            pixels_checked++;
            if (got.address !== want.address)
                report_mismatch("pixel_address", got.address, want.address);
            if (got.color !== want.color)
                report_mismatch("pixel_color", got.color, want.color);
            if (got.col !== want.col)
                report_mismatch("cursor_col", got.col, want.col);
            if (got.row !== want.row)
                report_mismatch("cursor_row", got.row, want.row);
            if (got.last !== want.last)
                report_mismatch("last_pixel", got.last, want.last);
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [7:0]             cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic [7:0]             controller_status;
    logic [7:0]             data_byte;
    logic                   out_valid;
    logic                   out_ready;
    logic [15:0]            pixel_address;
    logic [7:0]             pixel_color;
    logic [8:0]             cursor_col;
    logic [7:0]             cursor_row;
    logic                   last_pixel;

    cursor_pixel_board board;
    logic              calm;
    logic              hold_request;
    int                ignored_reads;

    ps2_mouse_cursor_tracker_core dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .controller_status (controller_status),
        .data_byte         (data_byte),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .pixel_address     (pixel_address),
        .pixel_color       (pixel_color),
        .cursor_col        (cursor_col),
        .cursor_row        (cursor_row),
        .last_pixel        (last_pixel)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int hold_left;
        hold_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= calm || ($urandom_range(99) >= 12);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (in_valid && in_ready)
            begin
                if (!(controller_status[STATUS_READY_BIT] && controller_status[STATUS_AUX_BIT]))
                    ignored_reads++;
                board.take_mouse_read(controller_status, data_byte);
            end
            if (cfg_valid && cfg_ready)
                board.write_register(cfg_index, cfg_data);
            if (out_valid && out_ready)
                board.match_pixel_write({pixel_address, pixel_color, cursor_col,
                                         cursor_row, last_pixel});
        end
    end

    function automatic logic [7:0] mouse_status();
        return 8'($urandom_range(255)) | STATUS_MOUSE;
    endfunction

    function automatic logic [7:0] noise_status();
        logic [7:0] s;
        s = 8'($urandom_range(255));
        if (s[STATUS_READY_BIT] && s[STATUS_AUX_BIT])
        begin
            if ($urandom_range(1) == 1)
                s[STATUS_READY_BIT] = 1'b0;
            else
                s[STATUS_AUX_BIT] = 1'b0;
        end
        return s;
    endfunction

    function automatic logic [7:0] motion();
        case ($urandom_range(7))
            0: return 8'h7F;
            1: return 8'h80;
            2: return 8'h00;
            3: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_read(input logic [7:0] status, input logic [7:0] value);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(99) < 12)
            gap = $urandom_range(4, 1);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        controller_status <= status;
        data_byte <= value;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic send_packet(input logic [7:0] status, input logic [7:0] buttons,
                               input logic [7:0] dx, input logic [7:0] dy);
        send_read(status, buttons);
        send_read(status, dx);
        send_read(status, dy);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic wait_for_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending_pixels.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic random_reads(input int count);
        int taken;
        int kind;
        taken = 0;
        while (taken < count)
        begin
            kind = $urandom_range(99);
            if (kind < 80)
            begin
                send_read(mouse_status(), 8'($urandom_range(255)));
                if ($urandom_range(9) == 0)
                    send_read(noise_status(), 8'($urandom_range(255)));
                send_read(mouse_status(), motion());
                send_read(mouse_status(), motion());
                taken += 3;
            end
            else if (kind < 92)
                send_read(noise_status(), 8'($urandom_range(255)));
            else
            begin
                send_read(mouse_status(), 8'($urandom_range(255)));
                taken++;
            end
        end
    endtask

    initial
    begin
        board = new();
        calm = 1'b0;
        hold_request = 1'b0;
        ignored_reads = 0;
        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_IDLE_COLOR;
        cfg_data <= 8'h00;
        in_valid <= 1'b0;
        controller_status <= 8'h00;
        data_byte <= 8'h00;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_read(STATUS_MOUSE, 8'h08);
        send_read(8'h00, 8'hFF);
        send_read(8'h01, 8'hAA);
        send_read(STATUS_MOUSE, 8'h00);
        send_read(8'h20, 8'h55);
        send_read(8'hDE, 8'h01);
        send_read(STATUS_MOUSE, 8'h00);
        send_packet(8'hFF, 8'h09, 8'h7F, 8'h7F);
        send_packet(STATUS_MOUSE, 8'h09, 8'h7F, 8'h80);
        send_packet(STATUS_MOUSE, 8'h08, 8'h7F, 8'h80);
        send_packet(8'hFF, 8'hFF, 8'h80, 8'h00);
        send_packet(STATUS_MOUSE, 8'h00, 8'h80, 8'h7F);
        send_packet(STATUS_MOUSE, 8'h01, 8'h80, 8'h00);
        wait_for_idle();

        write_reg(REG_IDLE_COLOR, 8'h00);
        write_reg(REG_PRESSED_COLOR, 8'hFF);
        write_reg(REG_UNMAPPED_LOW, 8'h5A);
        write_reg(REG_UNMAPPED_HIGH, 8'hA5);
        cfg_valid <= 1'b0;
        calm = 1'b1;
        random_reads(25);
        wait_for_idle();

        calm = 1'b0;
        write_reg(REG_IDLE_COLOR, 8'hFF);
        write_reg(REG_PRESSED_COLOR, 8'h00);
        cfg_valid <= 1'b0;
        hold_request = 1'b1;
        random_reads(25);
        wait_for_idle();

        write_reg(REG_PRESSED_COLOR, 8'($urandom_range(255)));
        write_reg(REG_IDLE_COLOR, 8'($urandom_range(255)));
        cfg_valid <= 1'b0;
        random_reads(25);
        wait_for_idle();
        repeat (20) @(posedge clk);

        if (board.pending_pixels.size() != 0)
            board.report_mismatch("pixel writes never seen", 0, board.pending_pixels.size());
        $display("Covered %0d mouse packets, %0d pixel writes and %0d ignored reads.",
                 board.packets_done, board.pixels_checked, ignored_reads);
        $display("Cursor pinned at a screen edge %0d times; %0d mismatches.",
                 board.clamp_hits, board.mismatches);
        if (board.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
